// ----- src/rrsg_pkg.sv -----
// Shared types and constants for the rounded rectangle span generator.
package rrsg_pkg;

	localparam int MAX_SCREEN = 1024;
	localparam int SCREEN_W = 11;
	localparam int ROOT_STEPS = 9;
	localparam int REM_W = 2 * ROOT_STEPS;

	localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SCREEN_W-1:0] SCREEN_RESET = 11'd412;

	typedef struct packed {
		logic signed [11:0] rect_left;
		logic signed [11:0] rect_top;
		logic [10:0] rect_width;
		logic [10:0] rect_height;
		logic [9:0] corner_radius;
		logic [15:0] fill_colour;
		logic [9:0] row_index;
	} rrsg_in_t;

	typedef struct packed {
		logic span_valid;
		logic [9:0] span_start_x;
		logic [9:0] span_end_x;
		logic [9:0] span_y;
		logic [15:0] span_colour;
	} rrsg_out_t;

	typedef struct packed {
		logic [9:0] x;
		logic [10:0] w;
		logic [9:0] r;
		logic [9:0] y;
		logic [15:0] colour;
		logic corner;
	} rrsg_side_t;

	typedef struct packed {
		rrsg_side_t side;
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] res;
	} rrsg_stage_t;

endpackage

// ----- src/rrsg_front.sv -----
// Front stages: clipping, radius clamp, corner detection and squaring.
module rrsg_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  rrsg_pkg::rrsg_in_t             in_data,
	input  logic [rrsg_pkg::SCREEN_W-1:0]  screen_width,
	input  logic [rrsg_pkg::SCREEN_W-1:0]  screen_height,
	output logic                           out_valid,
	output rrsg_pkg::rrsg_stage_t          out_data
);
	import rrsg_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [10:0] x_s1, y_s1;
	logic signed [12:0] w_s1, h_s1;
	logic [9:0] r_s1, row_s1;
	logic [15:0] colour_s1;

	logic [9:0] x_s2, y_s2, r_s2, row_s2;
	logic [10:0] w_s2, h_s2;
	logic [15:0] colour_s2;

	logic [9:0] x_s3, y_s3, r_s3, row_s3;
	logic [10:0] w_s3, h_s3;
	logic [15:0] colour_s3;

	rrsg_side_t side_s4, side_s5;
	logic [9:0] a_s4;
	logic [REM_W:0] rr_s5, aa_s5;
	rrsg_stage_t stage_s6;

	logic signed [12:0] lx, ly, lw, lh, wn, hn;
	logic [10:0] xn, yn;
	always_comb begin
		lx = 13'(in_data.rect_left);
		ly = 13'(in_data.rect_top);
		lw = signed'({2'b00, in_data.rect_width});
		lh = signed'({2'b00, in_data.rect_height});
		if (lx < 0) begin
			wn = lw + lx;
			xn = '0;
		end else begin
			wn = lw;
			xn = lx[10:0];
		end
		if (ly < 0) begin
			hn = lh + ly;
			yn = '0;
		end else begin
			hn = lh;
			yn = ly[10:0];
		end
	end

	logic [SCREEN_W-1:0] sw_lim, sh_lim;
	logic signed [13:0] sw_s, sh_s, xs_s, ys_s, wsum, hsum, wc, hc;
	always_comb begin
		sw_lim = (screen_width > SCREEN_W'(MAX_SCREEN)) ? SCREEN_W'(MAX_SCREEN) : screen_width;
		sh_lim = (screen_height > SCREEN_W'(MAX_SCREEN)) ? SCREEN_W'(MAX_SCREEN) : screen_height;
		sw_s = signed'({3'b000, sw_lim});
		sh_s = signed'({3'b000, sh_lim});
		xs_s = signed'({3'b000, x_s1});
		ys_s = signed'({3'b000, y_s1});
		wsum = xs_s + {w_s1[12], w_s1};
		hsum = ys_s + {h_s1[12], h_s1};
		wc = (wsum > sw_s) ? (sw_s - xs_s) : {w_s1[12], w_s1};
		hc = (hsum > sh_s) ? (sh_s - ys_s) : {h_s1[12], h_s1};
	end

	logic [9:0] r_clamp;
	always_comb begin
		r_clamp = r_s2;
		if (r_clamp > w_s2[10:1])
			r_clamp = w_s2[10:1];
		if (r_clamp > h_s2[10:1])
			r_clamp = h_s2[10:1];
	end

	logic top_band, bot_band;
	logic [10:0] bot_dist;
	logic [9:0] a_n;
	always_comb begin
		top_band = row_s3 < r_s3;
		bot_band = {1'b0, row_s3} >= (h_s3 - {1'b0, r_s3});
		bot_dist = {1'b0, r_s3} + {1'b0, row_s3} + 11'd1 - h_s3;
		if (top_band)
			a_n = r_s3 - row_s3;
		else if (bot_band)
			a_n = bot_dist[9:0];
		else
			a_n = r_s3;
	end

	logic [19:0] rr_full, aa_full;
	assign rr_full = 20'(side_s4.r) * 20'(side_s4.r);
	assign aa_full = 20'(a_s4) * 20'(a_s4);

	logic [REM_W:0] diff;
	assign diff = rr_s5 - aa_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1 && (wc > 0) && (hc > 0);
			valid_s3 <= valid_s2 && ({1'b0, row_s2} < h_s2);
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xn;
			y_s1 <= yn;
			w_s1 <= wn;
			h_s1 <= hn;
			r_s1 <= in_data.corner_radius;
			row_s1 <= in_data.row_index;
			colour_s1 <= in_data.fill_colour;

			x_s2 <= x_s1[9:0];
			y_s2 <= y_s1[9:0];
			w_s2 <= wc[10:0];
			h_s2 <= hc[10:0];
			r_s2 <= r_s1;
			row_s2 <= row_s1;
			colour_s2 <= colour_s1;

			x_s3 <= x_s2;
			y_s3 <= y_s2 + row_s2;
			w_s3 <= w_s2;
			h_s3 <= h_s2;
			r_s3 <= r_clamp;
			row_s3 <= row_s2;
			colour_s3 <= colour_s2;

			side_s4.x <= x_s3;
			side_s4.w <= w_s3;
			side_s4.r <= r_s3;
			side_s4.y <= y_s3;
			side_s4.colour <= colour_s3;
			side_s4.corner <= (r_s3 != '0) && (top_band || bot_band);
			a_s4 <= a_n;

			side_s5 <= side_s4;
			rr_s5 <= rr_full[REM_W:0];
			aa_s5 <= aa_full[REM_W:0];

			stage_s6.side <= side_s5;
			stage_s6.rem <= diff[REM_W-1:0];
			stage_s6.res <= '0;
		end
	end

	assign out_valid = valid_s6;
	assign out_data = stage_s6;

endmodule

// ----- src/rrsg_root_cell.sv -----
// One cell of the square root chain: settles one result bit per pass.
module rrsg_root_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [3:0]             step,
	input  logic                   in_valid,
	input  rrsg_pkg::rrsg_stage_t  in_data,
	output logic                   out_valid,
	output rrsg_pkg::rrsg_stage_t  out_data
);
	import rrsg_pkg::*;

	logic valid_q;
	rrsg_stage_t data_q;
	logic [REM_W-1:0] bitv;
	logic [REM_W:0] trial;
	rrsg_stage_t next;

	always_comb begin
		bitv = REM_W'(1) << {step, 1'b0};
		trial = {1'b0, in_data.res} + {1'b0, bitv};
		next = in_data;
		if ({1'b0, in_data.rem} >= trial) begin
			next.rem = in_data.rem - trial[REM_W-1:0];
			next.res = (in_data.res >> 1) + bitv;
		end else begin
			next.res = in_data.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= next;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

// ----- src/rounded_rect_span_generator.sv -----
// Top level of the rounded rectangle span generator.
//
//  Channel  Signals                          Width  Direction
//  input    in_valid, in_ready, in_data      82     in
//  result   out_valid, out_ready, out_data   47     out
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  2 + 11  in
//
// One item is taken every cycle unless the output stalls; each span passes through six front stages,
// nine square root cells and the output register.
// Reset clears every stage's valid bit and sets both screen sizes to 412.
// The whole pipeline holds while a result waits at the output and out_ready is low.
module rounded_rect_span_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  rrsg_pkg::rrsg_in_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output rrsg_pkg::rrsg_out_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [rrsg_pkg::SCREEN_W-1:0]  cfg_data
);
	import rrsg_pkg::*;

	logic en;
	logic [SCREEN_W-1:0] screen_width_q, screen_height_q;
	logic chain_valid [0:ROOT_STEPS];
	rrsg_stage_t chain_data [0:ROOT_STEPS];
	logic out_valid_q;
	rrsg_out_t out_data_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_RESET;
			screen_height_q <= SCREEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rrsg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.in_data       (in_data),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_valid     (chain_valid[0]),
		.out_data      (chain_data[0])
	);

	for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
		rrsg_root_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (4'(ROOT_STEPS - 1 - g)),
			.in_valid  (chain_valid[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_valid[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	rrsg_side_t fin;
	logic [9:0] dx;
	logic [9:0] xs, xe;
	always_comb begin
		fin = chain_data[ROOT_STEPS].side;
		dx = {1'b0, chain_data[ROOT_STEPS].res[ROOT_STEPS-1:0]};
		if (fin.corner && (dx != '0)) begin
			xs = fin.x + fin.r - dx;
			xe = 10'({1'b0, fin.x} + fin.w - {1'b0, fin.r} + {1'b0, dx});
		end else begin
			xs = fin.x;
			xe = 10'({1'b0, fin.x} + fin.w - 11'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= chain_valid[ROOT_STEPS] && (xe >= xs);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.span_valid <= 1'b1;
			out_data_q.span_start_x <= xs;
			out_data_q.span_end_x <= xe;
			out_data_q.span_y <= fin.y;
			out_data_q.span_colour <= fin.colour;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.span_start_x <= out_data.span_end_x)
		else $error("span start lies beyond span end");

	a_span_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.span_valid)
		else $error("span flag clear on a delivered span");

	a_root_below_radius: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[ROOT_STEPS] && fin.corner |-> dx < fin.r)
		else $error("corner offset not below the clamped radius");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the rounded rectangle span generator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rrsg_pkg::*;

	localparam int SPAN_LATENCY = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rrsg_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rrsg_out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_SCREEN_WIDTH;
	logic [SCREEN_W-1:0] cfg_data = '0;

	rrsg_in_t pending_items[$];
	rrsg_out_t span_expected[$];
	logic [SCREEN_W-1:0] model_width = SCREEN_RESET;
	logic [SCREEN_W-1:0] model_height = SCREEN_RESET;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;

	rounded_rect_span_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int floor_sqrt(input int v);
		int res;
		res = 0;
		for (int b = 1024; b > 0; b >>= 1) begin
			if ((res + b) * (res + b) <= v)
				res += b;
		end
		return res;
	endfunction

	function automatic int corner_half_width(input int r, input int dy);
		int ad;
		ad = (dy < 0) ? -dy : dy;
		if (ad * ad >= r * r)
			return 0;
		return floor_sqrt(r * r - ad * ad);
	endfunction

	function automatic bit predict_span(input rrsg_in_t item, input logic [SCREEN_W-1:0] sw_reg,
			input logic [SCREEN_W-1:0] sh_reg, output rrsg_out_t span);
		int x, y, w, h, r, row, sw, sh, xs, xe, off;
		x = int'($signed(item.rect_left));
		y = int'($signed(item.rect_top));
		w = int'(item.rect_width);
		h = int'(item.rect_height);
		r = int'(item.corner_radius);
		row = int'(item.row_index);
		sw = (sw_reg > MAX_SCREEN) ? MAX_SCREEN : int'(sw_reg);
		sh = (sh_reg > MAX_SCREEN) ? MAX_SCREEN : int'(sh_reg);
		span = '0;
		if (x < 0) begin
			w += x;
			x = 0;
		end
		if (y < 0) begin
			h += y;
			y = 0;
		end
		if (x + w > sw)
			w = sw - x;
		if (y + h > sh)
			h = sh - y;
		if (w <= 0 || h <= 0)
			return 1'b0;
		if (r > w / 2)
			r = w / 2;
		if (r > h / 2)
			r = h / 2;
		if (row >= h)
			return 1'b0;
		xs = x;
		xe = x + w - 1;
		if (r > 0) begin
			off = 0;
			if (row < r)
				off = corner_half_width(r, row - r);
			else if (row >= h - r)
				off = corner_half_width(r, (h - 1 - row) - r);
			if (off > 0) begin
				xs = x + r - off;
				xe = x + w - r + off;
			end
			if (xs < x)
				xs = x;
			if (xe > x + w - 1)
				xe = x + w - 1;
		end
		if (xe < xs)
			return 1'b0;
		span.span_valid = 1'b1;
		span.span_start_x = 10'(xs);
		span.span_end_x = 10'(xe);
		span.span_y = 10'(y + row);
		span.span_colour = item.fill_colour;
		return 1'b1;
	endfunction

	function automatic rrsg_in_t make_item(input int left, input int top, input int w, input int h,
			input int r, input int colour, input int row);
		rrsg_in_t item;
		item.rect_left = 12'(left);
		item.rect_top = 12'(top);
		item.rect_width = 11'(w);
		item.rect_height = 11'(h);
		item.corner_radius = 10'(r);
		item.fill_colour = 16'(colour);
		item.row_index = 10'(row);
		return item;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : accept_input
		rrsg_out_t span;
		if (arst_n && in_valid && in_ready) begin
			if (predict_span(in_data, model_width, model_height, span))
				span_expected.push_back(span);
		end
	end

	always @(posedge clk) begin : check_output
		rrsg_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (span_expected.size() == 0) begin
				$error("span transaction with none expected: %h", out_data);
				mismatches++;
			end else begin
				want = span_expected.pop_front();
				check_field("span_valid", 32'(want.span_valid), 32'(out_data.span_valid));
				check_field("span_start_x", 32'(want.span_start_x),
					32'(out_data.span_start_x));
				check_field("span_end_x", 32'(want.span_end_x), 32'(out_data.span_end_x));
				check_field("span_y", 32'(want.span_y), 32'(out_data.span_y));
				check_field("span_colour", 32'(want.span_colour), 32'(out_data.span_colour));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_screen_reg(input logic [1:0] idx, input logic [SCREEN_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_SCREEN_WIDTH)
			model_width = val;
		else if (idx == REG_SCREEN_HEIGHT)
			model_height = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || span_expected.size() != 0);
		repeat (2 * SPAN_LATENCY) @(posedge clk);
	endtask

	task automatic push_random_item();
		logic [95:0] raw;
		int esw, esh, left, top, wid, hgt, rad, ch, y0, band, row;
		esw = (model_width > MAX_SCREEN) ? MAX_SCREEN : int'(model_width);
		esh = (model_height > MAX_SCREEN) ? MAX_SCREEN : int'(model_height);
		if ($urandom_range(99) < 20) begin
			raw = {$urandom, $urandom, $urandom};
			pending_items.push_back(raw[$bits(rrsg_in_t)-1:0]);
		end else begin
			left = int'($urandom_range(0, esw + 40)) - 20;
			top = int'($urandom_range(0, esh + 40)) - 20;
			wid = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 120);
			hgt = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 120);
			rad = ($urandom_range(4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
			ch = hgt;
			y0 = top;
			if (y0 < 0) begin
				ch += y0;
				y0 = 0;
			end
			if (y0 + ch > esh)
				ch = esh - y0;
			if (ch < 1)
				ch = 1;
			band = (rad < ch / 2) ? rad : ch / 2;
			case ($urandom_range(3))
				0: row = $urandom_range(0, band);
				1: row = ch - 1 - int'($urandom_range(0, band));
				2: row = $urandom_range(0, ch);
				default: row = $urandom_range(0, 1023);
			endcase
			if (row < 0)
				row = 0;
			if (row > 1023)
				row = 1023;
			pending_items.push_back(make_item(left, top, wid, hgt, rad,
				$urandom_range(0, 65535), row));
		end
	endtask

	task automatic run_phase(input int sw, input int sh, input int unsigned idle_pct,
			input int unsigned stall, input int count);
		write_screen_reg(REG_SCREEN_WIDTH, SCREEN_W'(sw));
		write_screen_reg(REG_SCREEN_HEIGHT, SCREEN_W'(sh));
		@(negedge clk);
		send_idle_pct = idle_pct;
		stall_pct = stall;
		repeat (count) push_random_item();
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		pending_items.push_back(make_item(10, 20, 100, 50, 0, 'hF800, 0));
		pending_items.push_back(make_item(10, 20, 100, 50, 0, 'hF800, 49));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 0));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 1));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 5));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 10));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 30));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 39));
		pending_items.push_back(make_item(50, 60, 40, 40, 10, 'h07E0, 40));
		pending_items.push_back(make_item(0, 0, 0, 10, 3, 'h001F, 0));
		pending_items.push_back(make_item(0, 0, 10, 0, 3, 'h001F, 0));
		pending_items.push_back(make_item(-2048, 5, 100, 10, 2, 'h5555, 0));
		pending_items.push_back(make_item(2047, 5, 10, 10, 2, 'hAAAA, 0));
		pending_items.push_back(make_item(-5, -7, 50, 50, 8, 'h1234, 0));
		pending_items.push_back(make_item(400, 405, 100, 100, 6, 'h4321, 3));
		pending_items.push_back(make_item(100, 100, 20, 60, 1023, 'h0F0F, 0));
		pending_items.push_back(make_item(100, 100, 20, 60, 1023, 'h0F0F, 4));
		pending_items.push_back(make_item(200, 200, 2, 2, 1, 'hF0F0, 1));
		pending_items.push_back(make_item(-1, -1, 2047, 2047, 1023, 'hFFFF, 1023));
		pending_items.push_back(make_item(0, 0, 0, 0, 0, 'h0000, 0));
		pending_items.push_back(make_item(0, 0, 412, 412, 206, 'h1234, 205));
		pending_items.push_back(make_item(0, 0, 412, 412, 1023, 'hABCD, 411));
		pending_items.push_back(make_item(-1, -1, 2047, 2047, 1023, 'hFFFF, 206));
		wait_drained();

		run_phase(1024, 1024, 0, 0, 200);
		run_phase(2047, 2047, 78, 0, 200);
		run_phase(412, 640, 0, 78, 200);
		run_phase(1, 1, 19, 19, 50);
		run_phase(0, 2047, 0, 0, 30);
		run_phase(700, 0, 78, 0, 30);
		run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), 0, 78, 200);
		run_phase($urandom_range(1, 1024), $urandom_range(1, 1024), 19, 19, 200);
		run_phase(1024, 1, 0, 0, 100);
		run_phase(1, 1024, 19, 19, 100);

		if (mismatches == 0 && span_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
